@@ hw/rtl/jpeg_marker_stream_checker_defines.svh @@
// ----------------------------------------------------------------------------
// JPEG marker stream checker assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_STREAM_CHECKER_DEFINES_SVH
`define JPEG_MARKER_STREAM_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define JMSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("jmsc assertion failed");

// Condition must never be seen outside reset.
`define JMSC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("jmsc forbidden condition seen");

`else

`define JMSC_ASSERT(lbl, prop)
`define JMSC_ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ hw/rtl/jmsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsc_pkg
// Shared codes and types of the JPEG marker stream checker.
// ----------------------------------------------------------------------------
package jmsc_pkg;

  // Marker bytes
  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] CODE_ZERO     = 8'h00;
  localparam logic [7:0] CODE_TEM      = 8'h01;
  localparam logic [7:0] CODE_RST0     = 8'hD0;
  localparam logic [7:0] CODE_RST7     = 8'hD7;
  localparam logic [7:0] CODE_SOI      = 8'hD8;
  localparam logic [7:0] CODE_EOI      = 8'hD9;
  localparam logic [7:0] CODE_SOS      = 8'hDA;

  localparam logic [15:0] SEG_LEN_HDR  = 16'd2;

  typedef enum logic [1:0] {
    VERDICT_GOOD  = 2'd0,
    VERDICT_BAD   = 2'd1,
    VERDICT_SHORT = 2'd2,
    VERDICT_EXTRA = 2'd3
  } verdict_e;

  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } jmsc_res_t;

endpackage

@@ hw/rtl/jmsc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsc_core
// Marker parser state and per-word update; gives at most one verdict per file.
// ----------------------------------------------------------------------------
`include "jpeg_marker_stream_checker_defines.svh"

module jmsc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output jmsc_pkg::jmsc_res_t res_o
);

  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_CODE    = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_ENTROPY = 3'd5;
  localparam logic [2:0] PH_ENT_FF  = 3'd6;
  localparam logic [2:0] PH_PAD     = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic        ent_q, ent_d;
  logic        given_q, given_d;

  logic        do_code;
  logic        is_rst;
  logic [15:0] seg_len;
  jmsc_pkg::jmsc_res_t res;

  assign is_rst  = byte_i inside {[jmsc_pkg::CODE_RST0 : jmsc_pkg::CODE_RST7]};
  assign seg_len = {len_hi_q, byte_i};

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    len_hi_d    = len_hi_q;
    ent_d       = ent_q;
    do_code     = 1'b0;
    res.valid   = 1'b0;
    res.verdict = jmsc_pkg::VERDICT_BAD;

    case (phase_q)
      PH_PREFIX: begin
        if (byte_i != jmsc_pkg::MARKER_PREFIX) begin
          res.valid = 1'b1;
        end else begin
          phase_d = PH_CODE;
        end
      end
      PH_CODE: begin
        do_code = 1'b1;
      end
      PH_LEN_HI: begin
        len_hi_d = byte_i;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len > jmsc_pkg::SEG_LEN_HDR) begin
          skip_d  = seg_len - jmsc_pkg::SEG_LEN_HDR;
          phase_d = PH_SKIP;
        end else begin
          phase_d = ent_q ? PH_ENTROPY : PH_PREFIX;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - 16'd1;
        if (skip_q == 16'd1) begin
          phase_d = ent_q ? PH_ENTROPY : PH_PREFIX;
        end
      end
      PH_ENTROPY: begin
        if (byte_i == jmsc_pkg::MARKER_PREFIX) begin
          phase_d = PH_ENT_FF;
        end
      end
      PH_ENT_FF: begin
        // stuffed zero and restart markers stay inside the scan
        if (byte_i == jmsc_pkg::CODE_ZERO || is_rst) begin
          phase_d = PH_ENTROPY;
        end else if (byte_i == jmsc_pkg::MARKER_PREFIX) begin
          phase_d = PH_PAD;
        end else begin
          do_code = 1'b1;
        end
      end
      PH_PAD: begin
        if (byte_i != jmsc_pkg::MARKER_PREFIX) begin
          do_code = 1'b1;
        end
      end
      default: begin
        phase_d = PH_PREFIX;
      end
    endcase

    if (do_code) begin
      if (byte_i == jmsc_pkg::CODE_ZERO || is_rst) begin
        res.valid = 1'b1;
      end else if (byte_i == jmsc_pkg::CODE_EOI) begin
        res.valid   = 1'b1;
        res.verdict = last_i ? jmsc_pkg::VERDICT_GOOD : jmsc_pkg::VERDICT_EXTRA;
      end else if (byte_i == jmsc_pkg::CODE_SOI || byte_i == jmsc_pkg::CODE_TEM) begin
        phase_d = PH_PREFIX;
      end else begin
        ent_d   = (byte_i == jmsc_pkg::CODE_SOS);
        phase_d = PH_LEN_HI;
      end
    end

    if (!res.valid && last_i) begin
      res.valid   = 1'b1;
      res.verdict = jmsc_pkg::VERDICT_SHORT;
    end

    // after a verdict, hold everything until the file ends
    if (given_q) begin
      phase_d   = phase_q;
      skip_d    = skip_q;
      len_hi_d  = len_hi_q;
      ent_d     = ent_q;
      res.valid = 1'b0;
    end
    given_d = given_q | res.valid;

    if (last_i) begin
      phase_d  = PH_PREFIX;
      skip_d   = '0;
      len_hi_d = '0;
      ent_d    = 1'b0;
      given_d  = 1'b0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      skip_q   <= '0;
      len_hi_q <= '0;
      ent_q    <= 1'b0;
      given_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      len_hi_q <= len_hi_d;
      ent_q    <= ent_d;
      given_q  <= given_d;
    end
  end

  `JMSC_ASSERT(a_last_restarts, step_i && last_i |=> phase_q == PH_PREFIX && !given_q)
  `JMSC_ASSERT(a_last_gives_once, step_i && last_i && !given_q |-> res_o.valid)
  `JMSC_ASSERT_NEVER(a_skip_nonzero, phase_q == PH_SKIP && skip_q == 16'd0)
  `JMSC_ASSERT_NEVER(a_no_second_verdict, given_q && res_o.valid)

endmodule

@@ hw/rtl/jpeg_marker_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_stream_checker
// Checks the marker structure of a JPEG byte stream, one verdict per file.
// ----------------------------------------------------------------------------
//  channel  direction  fields (tdata low bit up / tuser / tlast)
//  s_axis   in         tdata: data_byte[7:0]; tlast: last_byte
//  m_axis   out        tdata: verdict[1:0], zeros above
//
//  One word per cycle sustained while no verdict waits unaccepted on m_axis.
//  Words pass an input register, then the parser update, then the result register.
//  A stalled result register stalls the parser stage; the input register still
//  takes a word whenever the parser stage moves on in the same cycle.
//  Reset (rst_ni low, asynchronous) returns the parser to expect a marker prefix.
// ----------------------------------------------------------------------------
`include "jpeg_marker_stream_checker_defines.svh"

module jpeg_marker_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [1:0] verdict, [7:2] zero
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_last_q;
  logic                out_valid_q;
  jmsc_pkg::verdict_e  verdict_q;
  logic                out_free;
  logic                fire;
  jmsc_pkg::jmsc_res_t res;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || fire;

  jmsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (fire && res.valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (fire && res.valid) begin
      verdict_q <= res.verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, verdict_q};

  `JMSC_ASSERT(a_verdict_lands, fire && res.valid |=> out_valid_q)
  `JMSC_ASSERT_NEVER(a_no_overwrite, fire && res.valid && out_valid_q && !m_axis_tready_i)
  `JMSC_ASSERT(a_hold_result, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule
